@@ rtl/mbt_pkg.sv @@
// types, codes and constants shared by the marker boundary table
`timescale 1ns / 1ps

package mbt_pkg;

   // field widths fixed by the item format
   localparam int COORD_BITS  = 12;
   localparam int IDX_W       = 6;
   localparam int CNT_OUT_W   = 7;
   localparam int BND_W       = 16;
   localparam int RATE_W      = 10;
   localparam int RATIO_W     = 9;

   // arithmetic unit width, wide enough for the merge threshold
   localparam int ALU_W       = 20;
   localparam int FRAC_BITS   = 8;
   localparam int RND_BIAS    = 1 << (FRAC_BITS - 1);

   // saturation limits of a stored boundary
   localparam logic signed [ALU_W-1:0] SAT_HI = ALU_W'((1 << (BND_W - 1)) - 1);
   localparam logic signed [ALU_W-1:0] SAT_LO = ALU_W'(-(1 << (BND_W - 1)));

   // register port
   localparam int CSR_W       = 32;
   localparam int CSR_AW      = 3;
   localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(0);
   localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(205);

   typedef enum logic [0:0] {
      REG_BUFFER_RATE,
      REG_MERGE_RATIO
   } reg_index_type;

   typedef enum logic [2:0] {
      OP_LOAD    = 3'd0,
      OP_MERGE   = 3'd1,
      OP_READ    = 3'd2,
      OP_NEAREST = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_RANGE,
      STAT_EMPTY
   } status_type;

   typedef enum logic [2:0] {
      ALU_MUL_RND,
      ALU_ADD,
      ALU_SUB,
      ALU_ABSDIFF,
      ALU_AVG
   } alu_mode_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_LD_MUL,
      S_LD_LO,
      S_LD_SUM,
      S_LD_HI,
      S_RD_DATA,
      S_MG_SPAN,
      S_MG_THR,
      S_MG_RD,
      S_MG_CMP,
      S_MG_AVG,
      S_NR_SCAN,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]            operation;
      logic                  axis;
      logic                  side;
      logic [COORD_BITS-1:0] position;
      logic [COORD_BITS-1:0] extent;
      logic [IDX_W-1:0]      index;
   } req_type;

   typedef struct packed {
      logic signed [BND_W-1:0] boundary;
      logic [IDX_W-1:0]        found_index;
      logic [CNT_OUT_W-1:0]    entry_count;
      logic [1:0]              status;
   } rsp_type;

endpackage

@@ rtl/mbt_mem.sv @@
// single write port, single registered read port boundary memory
`timescale 1ns / 1ps

module mbt_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule

@@ rtl/mbt_alu.sv @@
// shared arithmetic unit: rounded multiply, add, subtract, distance, average
`timescale 1ns / 1ps

module mbt_alu import mbt_pkg::*; (
   input  alu_mode_type            mode,
   input  logic signed [ALU_W-1:0] op_a,
   input  logic signed [ALU_W-1:0] op_b,
   input  logic signed [ALU_W-1:0] op_c,
   output logic signed [ALU_W-1:0] res,
   output logic                    lt
);

   logic signed [2*ALU_W-1:0] prod;
   logic signed [2*ALU_W-1:0] prod_rnd;
   logic signed [ALU_W-1:0]   diff;
   logic signed [ALU_W-1:0]   sum;

   // fixed point product, rounded half up
   assign prod     = op_a * op_b;
   assign prod_rnd = (prod + (2*ALU_W)'(RND_BIAS)) >>> FRAC_BITS;
   assign diff     = op_a - op_b;
   assign sum      = op_a + op_b;

   always_comb begin
      unique case (mode)
         ALU_MUL_RND: res = prod_rnd[ALU_W-1:0];
         ALU_ADD:     res = sum;
         ALU_SUB:     res = diff;
         ALU_ABSDIFF: res = (diff < 0) ? -diff : diff;
         ALU_AVG:     res = sum >>> 1;
         default:     res = sum;
      endcase
   end

   // compare against the third operand
   assign lt = (res < op_c);

endmodule

@@ rtl/marker_boundary_table.sv @@
// marker boundary table: load runs multiply, low write, sum and high write; clear and
// rejects go to the response; nearest makes one memory read per entry, pipelined against the
// compare; merge compares each adjacent pair on both axes (one or two uses of the shared
// unit per pair). busy is high from the accepting edge until the result goes out; a new
// start is taken in the cycle rsp_valid shows, and the receiver cannot stall a result.
// synchronous reset clears both counts, buffer_rate to 0, merge_ratio to 205; tables kept
`timescale 1ns / 1ps

module marker_boundary_table import mbt_pkg::*; #(
   parameter int MAX_MARKERS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_W-1:0]  pwdata,
   output logic [CSR_W-1:0]  prdata,
   output logic              pready
);

   localparam int AW    = $clog2(MAX_MARKERS);
   localparam int CNT_W = $clog2(MAX_MARKERS + 1);

   function automatic logic signed [BND_W-1:0] sat_bnd(input logic signed [ALU_W-1:0] v);
      logic signed [ALU_W-1:0] t;
      t = v;
      if (v > SAT_HI) begin
         t = SAT_HI;
      end else if (v < SAT_LO) begin
         t = SAT_LO;
      end
      return t[BND_W-1:0];
   endfunction

   // state and datapath registers
   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic [CNT_W-1:0]        hcnt_ff, hcnt_in;
   logic [CNT_W-1:0]        vcnt_ff, vcnt_in;
   logic [RATE_W-1:0]       rate_ff;
   logic [RATIO_W-1:0]      ratio_ff;
   logic signed [ALU_W-1:0] acc_ff, acc_in;
   logic signed [ALU_W-1:0] best_ff, best_in;
   logic signed [BND_W-1:0] bnd_ff, bnd_in;
   logic [AW-1:0]           found_ff, found_in;
   status_type              status_ff, status_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic                    ax_ff, ax_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // shared unit
   alu_mode_type            alu_mode;
   logic signed [ALU_W-1:0] alu_a, alu_b, alu_c, alu_res;
   logic                    alu_lt;

   // memory ports
   logic [AW-1:0]    rd_lo_addr, rd_hi_addr, wr_lo_addr, wr_hi_addr;
   logic [BND_W-1:0] wr_data;
   logic             we_lo, we_hi, wax;
   logic [BND_W-1:0] hl_q, hh_q, vl_q, vh_q;

   // derived control values
   logic [CNT_W-1:0]        cnt_sel, n_ax, i_nx, i_prev;
   logic [CNT_W:0]          i_plus2;
   logic                    more_pairs, next_axis;
   logic                    load_full, merge_empty, read_range;
   logic signed [BND_W-1:0] tab_q, lo_q, hi_q;
   logic signed [ALU_W-1:0] pos_ext, ext_ext;
   logic [AW-1:0]           load_addr;
   logic                    csr_wr;

   assign cnt_sel     = req_ff.axis ? vcnt_ff : hcnt_ff;
   assign n_ax        = ax_ff ? vcnt_ff : hcnt_ff;
   assign i_nx        = i_ff + CNT_W'(1);
   assign i_prev      = i_ff - CNT_W'(1);
   assign i_plus2     = {1'b0, i_ff} + (CNT_W+1)'(2);
   assign more_pairs  = (i_plus2 < {1'b0, n_ax});
   assign next_axis   = !ax_ff && (vcnt_ff >= CNT_W'(2));
   assign load_full   = (cnt_sel == CNT_W'(MAX_MARKERS));
   assign merge_empty = (hcnt_ff == '0) || (vcnt_ff == '0);
   assign read_range  = ((CNT_W+IDX_W)'(req_ff.index) >= (CNT_W+IDX_W)'(cnt_sel));
   assign load_addr   = cnt_sel[AW-1:0];
   assign pos_ext     = ALU_W'(req_ff.position);
   assign ext_ext     = ALU_W'(req_ff.extent);

   // table selection for read and nearest, pair selection for merge
   assign tab_q = req_ff.side ? (req_ff.axis ? vh_q : hh_q) : (req_ff.axis ? vl_q : hl_q);
   assign lo_q  = ax_ff ? vl_q : hl_q;
   assign hi_q  = ax_ff ? vh_q : hh_q;

   mbt_alu u_alu (
      .mode (alu_mode),
      .op_a (alu_a),
      .op_b (alu_b),
      .op_c (alu_c),
      .res  (alu_res),
      .lt   (alu_lt)
   );

   mbt_mem #(.DEPTH(MAX_MARKERS), .ADDR_W(AW), .DATA_W(BND_W)) u_horiz_low (
      .clock   (clock),
      .wr_en   (we_lo & ~wax),
      .wr_addr (wr_lo_addr),
      .wr_data (wr_data),
      .rd_addr (rd_lo_addr),
      .rd_data (hl_q)
   );

   mbt_mem #(.DEPTH(MAX_MARKERS), .ADDR_W(AW), .DATA_W(BND_W)) u_horiz_high (
      .clock   (clock),
      .wr_en   (we_hi & ~wax),
      .wr_addr (wr_hi_addr),
      .wr_data (wr_data),
      .rd_addr (rd_hi_addr),
      .rd_data (hh_q)
   );

   mbt_mem #(.DEPTH(MAX_MARKERS), .ADDR_W(AW), .DATA_W(BND_W)) u_vert_low (
      .clock   (clock),
      .wr_en   (we_lo & wax),
      .wr_addr (wr_lo_addr),
      .wr_data (wr_data),
      .rd_addr (rd_lo_addr),
      .rd_data (vl_q)
   );

   mbt_mem #(.DEPTH(MAX_MARKERS), .ADDR_W(AW), .DATA_W(BND_W)) u_vert_high (
      .clock   (clock),
      .wr_en   (we_hi & wax),
      .wr_addr (wr_hi_addr),
      .wr_data (wr_data),
      .rd_addr (rd_hi_addr),
      .rd_data (vh_q)
   );

   // register port
   assign csr_wr = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_RESET;
         ratio_ff <= RATIO_RESET;
      end else if (csr_wr) begin
         unique case (reg_index_type'(paddr[2]))
            REG_BUFFER_RATE: rate_ff  <= pwdata[RATE_W-1:0];
            REG_MERGE_RATIO: ratio_ff <= pwdata[RATIO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_BUFFER_RATE: prdata = CSR_W'(rate_ff);
         REG_MERGE_RATIO: prdata = CSR_W'(ratio_ff);
         default:         prdata = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (req_ff.operation)
               OP_LOAD:    state_in = load_full ? S_RESP : S_LD_MUL;
               OP_MERGE:   state_in = merge_empty ? S_RESP : S_MG_SPAN;
               OP_READ:    state_in = read_range ? S_RESP : S_RD_DATA;
               OP_NEAREST: state_in = (cnt_sel == '0) ? S_RESP : S_NR_SCAN;
               default:    state_in = S_RESP;
            endcase
         end
         S_LD_MUL:  state_in = S_LD_LO;
         S_LD_LO:   state_in = S_LD_SUM;
         S_LD_SUM:  state_in = S_LD_HI;
         S_LD_HI:   state_in = S_RESP;
         S_RD_DATA: state_in = S_RESP;
         S_MG_SPAN: state_in = S_MG_THR;
         S_MG_THR: begin
            if ((hcnt_ff >= CNT_W'(2)) || (vcnt_ff >= CNT_W'(2))) begin
               state_in = S_MG_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_MG_RD:   state_in = S_MG_CMP;
         S_MG_CMP: begin
            if (alu_lt) begin
               state_in = S_MG_AVG;
            end else if (more_pairs || next_axis) begin
               state_in = S_MG_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_MG_AVG: begin
            if (more_pairs || next_axis) begin
               state_in = S_MG_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_NR_SCAN: begin
            if (i_ff == cnt_sel) begin
               state_in = S_RESP;
            end
         end
         S_RESP:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // sequencer outputs and datapath updates
   always_comb begin
      req_in       = req_ff;
      hcnt_in      = hcnt_ff;
      vcnt_in      = vcnt_ff;
      acc_in       = acc_ff;
      best_in      = best_ff;
      bnd_in       = bnd_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      i_in         = i_ff;
      ax_in        = ax_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      alu_mode     = ALU_ADD;
      alu_a        = '0;
      alu_b        = '0;
      alu_c        = '0;
      rd_lo_addr   = '0;
      rd_hi_addr   = '0;
      wr_lo_addr   = load_addr;
      wr_hi_addr   = load_addr;
      wr_data      = '0;
      we_lo        = 1'b0;
      we_hi        = 1'b0;
      wax          = req_ff.axis;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in    = req_data;
               bnd_in    = '0;
               found_in  = '0;
               status_in = STAT_OK;
            end
         end
         S_DISPATCH: begin
            // read address for a read; entry 0 for the merge span
            if (req_ff.operation == OP_READ) begin
               rd_lo_addr = AW'(req_ff.index);
               rd_hi_addr = AW'(req_ff.index);
            end
            i_in = '0;
            unique case (req_ff.operation)
               OP_LOAD:    if (load_full) status_in = STAT_FULL;
               OP_MERGE:   if (merge_empty) status_in = STAT_EMPTY;
               OP_READ:    if (read_range) status_in = STAT_RANGE;
               OP_NEAREST: if (cnt_sel == '0) status_in = STAT_EMPTY;
               OP_CLEAR: begin
                  hcnt_in = '0;
                  vcnt_in = '0;
               end
               default: ;
            endcase
         end
         S_LD_MUL: begin
            // buffer = round(rate * extent)
            alu_mode = ALU_MUL_RND;
            alu_a    = ext_ext;
            alu_b    = ALU_W'(rate_ff);
            acc_in   = alu_res;
         end
         S_LD_LO: begin
            alu_mode = ALU_SUB;
            alu_a    = pos_ext;
            alu_b    = acc_ff;
            wr_data  = sat_bnd(alu_res);
            we_lo    = 1'b1;
            if (!req_ff.side) begin
               bnd_in = sat_bnd(alu_res);
            end
         end
         S_LD_SUM: begin
            alu_mode = ALU_ADD;
            alu_a    = ext_ext;
            alu_b    = acc_ff;
            acc_in   = alu_res;
         end
         S_LD_HI: begin
            alu_mode = ALU_ADD;
            alu_a    = pos_ext;
            alu_b    = acc_ff;
            wr_data  = sat_bnd(alu_res);
            we_hi    = 1'b1;
            found_in = load_addr;
            if (req_ff.side) begin
               bnd_in = sat_bnd(alu_res);
            end
            if (req_ff.axis) begin
               vcnt_in = vcnt_ff + CNT_W'(1);
            end else begin
               hcnt_in = hcnt_ff + CNT_W'(1);
            end
         end
         S_RD_DATA: begin
            bnd_in = tab_q;
         end
         S_MG_SPAN: begin
            alu_mode = ALU_SUB;
            alu_a    = ALU_W'($signed(vh_q));
            alu_b    = ALU_W'($signed(vl_q));
            acc_in   = alu_res;
         end
         S_MG_THR: begin
            // threshold = round(ratio * span), held in acc for the whole merge
            alu_mode = ALU_MUL_RND;
            alu_a    = acc_ff;
            alu_b    = ALU_W'(ratio_ff);
            acc_in   = alu_res;
            i_in     = '0;
            ax_in    = (hcnt_ff < CNT_W'(2));
         end
         S_MG_RD: begin
            rd_hi_addr = i_ff[AW-1:0];
            rd_lo_addr = i_nx[AW-1:0];
         end
         S_MG_CMP: begin
            rd_hi_addr = i_ff[AW-1:0];
            rd_lo_addr = i_nx[AW-1:0];
            alu_mode   = ALU_SUB;
            alu_a      = ALU_W'(lo_q);
            alu_b      = ALU_W'(hi_q);
            alu_c      = acc_ff;
            if (!alu_lt) begin
               if (more_pairs) begin
                  i_in = i_nx;
               end else if (next_axis) begin
                  ax_in = 1'b1;
                  i_in  = '0;
               end
            end
         end
         S_MG_AVG: begin
            // join the pair at the floor average
            rd_hi_addr = i_ff[AW-1:0];
            rd_lo_addr = i_nx[AW-1:0];
            alu_mode   = ALU_AVG;
            alu_a      = ALU_W'(lo_q);
            alu_b      = ALU_W'(hi_q);
            wr_hi_addr = i_ff[AW-1:0];
            wr_lo_addr = i_nx[AW-1:0];
            wr_data    = alu_res[BND_W-1:0];
            we_lo      = 1'b1;
            we_hi      = 1'b1;
            wax        = ax_ff;
            if (more_pairs) begin
               i_in = i_nx;
            end else if (next_axis) begin
               ax_in = 1'b1;
               i_in  = '0;
            end
         end
         S_NR_SCAN: begin
            // read entry i while comparing entry i-1
            rd_lo_addr = i_ff[AW-1:0];
            rd_hi_addr = i_ff[AW-1:0];
            alu_mode   = ALU_ABSDIFF;
            alu_a      = ALU_W'(tab_q);
            alu_b      = pos_ext;
            alu_c      = best_ff;
            if ((i_ff != '0) && ((i_ff == CNT_W'(1)) || alu_lt)) begin
               best_in  = alu_res;
               found_in = i_prev[AW-1:0];
               bnd_in   = tab_q;
            end
            i_in = i_nx;
         end
         S_RESP: begin
            rsp_valid_in       = 1'b1;
            rsp_in.boundary    = bnd_ff;
            rsp_in.found_index = IDX_W'(found_ff);
            rsp_in.entry_count = CNT_OUT_W'(cnt_sel);
            rsp_in.status      = status_ff;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         hcnt_ff      <= '0;
         vcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hcnt_ff      <= hcnt_in;
         vcnt_ff      <= vcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      acc_ff    <= acc_in;
      best_ff   <= best_in;
      bnd_ff    <= bnd_in;
      found_ff  <= found_in;
      status_ff <= status_in;
      i_ff      <= i_in;
      ax_ff     <= ax_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
